// ===== rtl/core/rcl_pkg.sv =====
// ============================================================================
// rcl_pkg: shared types and constants of the rotor cipher letter block
// Command codes, field widths, character constants and the mod table builder.
// ============================================================================
package rcl_pkg;

    localparam int SYM_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int SEL_W      = 3;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int MOD_TAB_N  = 32;
    localparam int MAX_LW     = 6;
    localparam int RING_REG_COUNT = 3;

    // input op codes
    localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_POS = 2'd2;

    // fixed table selectors
    localparam logic [SEL_W-1:0] SEL_REFLECTOR = 3'd3;
    localparam logic [SEL_W-1:0] SEL_PLUGBOARD = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_READY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LOWER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_FIRST = 3'd2;

    // ASCII
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [2:0] {
        CMD_LETTER,
        CMD_PASS,
        CMD_REFUSE,
        CMD_LOAD_ROTOR,
        CMD_LOAD_REFL,
        CMD_LOAD_PLUG,
        CMD_SET_POS,
        CMD_DROP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               is_lower;
        logic               lower_out;
        logic [CHAR_W-1:0]  char_val;
        logic [SEL_W-1:0]   sel;
        logic [SYM_W-1:0]   index;
        logic [SYM_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } bk_status_t;

    typedef logic [MOD_TAB_N-1:0][MAX_LW-1:0] mod_tab_t;

    // v mod n for every 5-bit v, built at elaboration
    function automatic mod_tab_t build_mod_tab(input int n);
        mod_tab_t tab;
        int       r;
        for (int v = 0; v < MOD_TAB_N; v++)
        begin
            r = v;
            for (int k = 0; k < MOD_TAB_N; k++)
            begin
                if (r >= n)
                begin
                    r = r - n;
                end
            end
            tab[v] = MAX_LW'(r);
        end
        return tab;
    endfunction

endpackage

// ===== rtl/core/rcl_chan_if.sv =====
// ============================================================================
// rcl_chan_if: valid/ready channels of the rotor cipher letter block
// Input command channel and result channel.
// ============================================================================
interface rcl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] char_in;
    logic [2:0] table_sel;
    logic [4:0] entry_index;
    logic [4:0] entry_value;

    modport source (output valid, output op, output char_in, output table_sel,
                    output entry_index, output entry_value, input ready);
    modport sink   (input valid, input op, input char_in, input table_sel,
                    input entry_index, input entry_value, output ready);
endinterface

interface rcl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       refused;

    modport source (output valid, output char_out, output refused, input ready);
    modport sink   (input valid, input char_out, input refused, output ready);
endinterface

// ===== rtl/core/rotor_cipher_letter_top.sv =====
// Timing: a letter beat's result is registered once its plugboard, rotor, reflector,
//   rotor and plugboard lookups are done; pass-through and refused beats go straight to the output register.
// Throughput: a letter holds the engine, and no other beat is popped, until its chain of
//   dependent table reads ends, one RAM read per cycle; other beats 1/cycle while the output is free.
// Reset: rst_n is asynchronous, active low; clears config, rotor positions, queue
//   and output valid. Wiring tables are not cleared and must be loaded before use.
// ============================================================================
// rotor_cipher_letter_top: three-rotor reflector cipher, one character per beat
// Front end sorts input beats into commands, a two-entry queue buffers them,
// and the back end runs the plugboard / rotor / reflector lookup chain.
// ============================================================================
module rotor_cipher_letter_top #(
    parameter int ALPHABET_SIZE = 26,
    parameter int ROTOR_COUNT   = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rcl_in_if.sink                            din,
    rcl_out_if.source                         dout,
    input  logic                              cfg_we,
    input  logic [rcl_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [rcl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rcl_pkg::*;

    localparam int LW     = $clog2(ALPHABET_SIZE);
    // only the first three rotors have a ring setting register
    localparam int RING_N = (ROTOR_COUNT < RING_REG_COUNT) ? ROTOR_COUNT : RING_REG_COUNT;
    localparam mod_tab_t MOD_TAB = build_mod_tab(ALPHABET_SIZE);

    logic                           key_ready_reg;
    logic                           keep_lower_reg;
    logic [RING_N-1:0][LW-1:0]      ring_reg;
    logic [ROTOR_COUNT-1:0][LW-1:0] ring;

    logic       q_push;
    logic       q_full;
    logic       q_valid;
    cmd_t       q_in;
    cmd_t       q_head;
    bk_status_t bk_stat;

    // config writes; ring settings are stored already reduced mod alphabet size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_ready_reg  <= 1'b0;
            keep_lower_reg <= 1'b0;
            ring_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_KEY_READY:
                begin
                    key_ready_reg <= cfg_data[0];
                end
                CFG_KEEP_LOWER:
                begin
                    keep_lower_reg <= cfg_data[0];
                end
                default:
                begin
                    for (int r = 0; r < RING_N; r++)
                    begin
                        if (cfg_idx == CFG_IDX_W'(int'(CFG_RING_FIRST) + r))
                        begin
                            ring_reg[r] <= MOD_TAB[cfg_data][LW-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // rotors past the third run with ring offset zero
    for (genvar g = 0; g < ROTOR_COUNT; g++)
    begin : g_ring
        if (g < RING_N)
        begin : g_reg
            assign ring[g] = ring_reg[g];
        end
        else
        begin : g_zero
            assign ring[g] = '0;
        end
    end

    rcl_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ROTOR_COUNT   (ROTOR_COUNT)
    ) u_front (
        .din        (din),
        .key_ready  (key_ready_reg),
        .keep_lower (keep_lower_reg),
        .q_full     (q_full),
        .push       (q_push),
        .push_data  (q_in)
    );

    rcl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (bk_stat.pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // back end pops a result-producing command only when the output slot is free
    rcl_back #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ROTOR_COUNT   (ROTOR_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .ring    (ring),
        .status  (bk_stat),
        .dout    (dout)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.pop |-> q_valid)
        else $error("pop from empty command queue");

    a_run_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bk_stat.busy) |-> $past(bk_stat.pop))
        else $error("lookup chain started without a popped command");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.refused) |-> (dout.char_out == '0))
        else $error("refused beat carries a character");
`endif

endmodule

// ===== rtl/core/rcl_ram.sv =====
// ============================================================================
// rcl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module rcl_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rcl_front.sv =====
// ============================================================================
// rcl_front: command intake
// Accepts input beats and sorts them into commands for the back end.
// ============================================================================
module rcl_front #(
    parameter int ALPHABET_SIZE = 26,
    parameter int ROTOR_COUNT   = 3
) (
    rcl_in_if.sink         din,
    input  logic           key_ready,
    input  logic           keep_lower,
    input  logic           q_full,
    output logic           push,
    output rcl_pkg::cmd_t  push_data
);
    import rcl_pkg::*;

    logic      is_upper;
    logic      is_lower;
    cmd_kind_t kind;

    assign is_upper = (din.char_in >= CHAR_UPPER_A) && (din.char_in <= CHAR_UPPER_Z);
    assign is_lower = (din.char_in >= CHAR_LOWER_A) && (din.char_in <= CHAR_LOWER_Z);

    always_comb
    begin
        kind = CMD_DROP;
        unique case (din.op)
            OP_ENCRYPT:
            begin
                if (!key_ready)
                begin
                    kind = CMD_REFUSE;
                end
                else if (is_upper || is_lower)
                begin
                    kind = CMD_LETTER;
                end
                else
                begin
                    kind = CMD_PASS;
                end
            end
            OP_LOAD:
            begin
                if (int'(din.entry_index) >= ALPHABET_SIZE)
                begin
                    kind = CMD_DROP;
                end
                else if (din.table_sel == SEL_REFLECTOR)
                begin
                    kind = CMD_LOAD_REFL;
                end
                else if (din.table_sel == SEL_PLUGBOARD)
                begin
                    kind = CMD_LOAD_PLUG;
                end
                else if (int'(din.table_sel) < ROTOR_COUNT)
                begin
                    kind = CMD_LOAD_ROTOR;
                end
            end
            OP_SET_POS:
            begin
                if (din.table_sel != SEL_REFLECTOR && din.table_sel != SEL_PLUGBOARD
                    && int'(din.table_sel) < ROTOR_COUNT)
                begin
                    kind = CMD_SET_POS;
                end
            end
            default:
            begin
                kind = CMD_DROP;
            end
        endcase
    end

    assign din.ready = !q_full;
    // dropped beats are taken and forgotten here
    assign push = din.valid && !q_full && (kind != CMD_DROP);

    assign push_data.kind      = kind;
    assign push_data.is_lower  = is_lower;
    assign push_data.lower_out = keep_lower && is_lower;
    assign push_data.char_val  = din.char_in;
    assign push_data.sel       = din.table_sel;
    assign push_data.index     = din.entry_index;
    assign push_data.value     = din.entry_value;

endmodule

// ===== rtl/core/rcl_queue.sv =====
// ============================================================================
// rcl_queue: two-entry command queue
// Decouples the intake from the cipher engine.
// ============================================================================
module rcl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rcl_pkg::cmd_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output rcl_pkg::cmd_t  head
);
    import rcl_pkg::*;

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = ent_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/rcl_back.sv =====
// ============================================================================
// rcl_back: cipher engine
// Runs table loads, position writes and the letter lookup chain.
// ============================================================================
module rcl_back #(
    parameter int ALPHABET_SIZE = 26,
    parameter int ROTOR_COUNT   = 3
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          q_valid,
    input  rcl_pkg::cmd_t                                 q_head,
    input  logic [ROTOR_COUNT-1:0][$clog2(ALPHABET_SIZE)-1:0] ring,
    output rcl_pkg::bk_status_t                           status,
    rcl_out_if.source                                     dout
);
    import rcl_pkg::*;

    localparam int LW     = $clog2(ALPHABET_SIZE);
    localparam int RW     = (ROTOR_COUNT > 1) ? $clog2(ROTOR_COUNT) : 1;
    localparam int NSTG   = 2 * ROTOR_COUNT + 3;
    localparam int KW     = $clog2(NSTG);
    localparam int RDEPTH = ROTOR_COUNT * ALPHABET_SIZE;
    localparam int RAW    = $clog2(RDEPTH);
    localparam mod_tab_t MOD_TAB = build_mod_tab(ALPHABET_SIZE);
    localparam logic [LW:0]    N_W  = (LW + 1)'(ALPHABET_SIZE);
    localparam logic [RAW-1:0] N_RA = RAW'(ALPHABET_SIZE);
    localparam logic [LW-1:0]  TOP_POS = LW'(ALPHABET_SIZE - 1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    function automatic logic [LW-1:0] reduce(input logic [SYM_W-1:0] v);
        return MOD_TAB[v][LW-1:0];
    endfunction

    function automatic logic [LW-1:0] add_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= N_W)
        begin
            s = s - N_W;
        end
        return s[LW-1:0];
    endfunction

    function automatic logic [LW-1:0] sub_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + N_W - {1'b0, b};
        if (s >= N_W)
        begin
            s = s - N_W;
        end
        return s[LW-1:0];
    endfunction

    // stage order: plugboard, rotors up, reflector, rotors down, plugboard
    function automatic logic stg_is_rotor(input int k);
        return (k >= 1 && k <= ROTOR_COUNT) || (k >= ROTOR_COUNT + 2 && k <= 2 * ROTOR_COUNT + 1);
    endfunction

    function automatic logic stg_is_refl(input int k);
        return k == ROTOR_COUNT + 1;
    endfunction

    function automatic logic [RW-1:0] stg_rotor(input int k);
        int r;
        r = 0;
        if (k >= 1 && k <= ROTOR_COUNT)
        begin
            r = k - 1;
        end
        else if (k >= ROTOR_COUNT + 2 && k <= 2 * ROTOR_COUNT + 1)
        begin
            r = 2 * ROTOR_COUNT + 1 - k;
        end
        return RW'(r);
    endfunction

    function automatic logic [RAW-1:0] rot_base(input logic [RW-1:0] r);
        return RAW'(r) * N_RA;
    endfunction

    state_t                         state_reg, state_next;
    logic [KW-1:0]                  k_reg, k_next;
    logic [ROTOR_COUNT-1:0][LW-1:0] pos_reg, pos_next;
    logic [LW-1:0]                  off_a_reg, off_a_next;
    logic [LW-1:0]                  off_b_reg, off_b_next;
    logic                           lower_reg, lower_next;
    logic                           out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]              out_char_reg, out_char_next;
    logic                           out_refused_reg, out_refused_next;

    logic                           plug_we, refl_we, rot_we;
    logic [LW-1:0]                  ltr_waddr, ltr_raddr;
    logic [RAW-1:0]                 rot_waddr, rot_raddr;
    logic [SYM_W-1:0]               plug_rdata, refl_rdata, rot_rdata;

    logic [ROTOR_COUNT-1:0][LW-1:0] adv;
    logic                           carry;
    logic                           pop;
    logic                           out_free;
    logic                           needs_out;
    logic [SYM_W-1:0]               raw;
    logic [LW-1:0]                  vr;
    logic [LW-1:0]                  val;
    logic [LW-1:0]                  c0;
    logic [RW-1:0]                  r_ahead;
    int                             k_cur;

    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        pos_next         = pos_reg;
        off_a_next       = off_a_reg;
        off_b_next       = off_b_reg;
        lower_next       = lower_reg;
        out_valid_next   = out_valid_reg;
        out_char_next    = out_char_reg;
        out_refused_next = out_refused_reg;
        plug_we          = 1'b0;
        refl_we          = 1'b0;
        rot_we           = 1'b0;
        pop              = 1'b0;

        k_cur     = int'(k_reg);
        ltr_waddr = LW'(q_head.index);
        rot_waddr = rot_base(RW'(q_head.sel)) + RAW'(q_head.index);
        out_free  = !out_valid_reg || dout.ready;
        needs_out = (q_head.kind inside {CMD_LETTER, CMD_PASS, CMD_REFUSE});

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        // letter index of the queued character
        c0 = reduce(SYM_W'(q_head.char_val - (q_head.is_lower ? CHAR_LOWER_A : CHAR_UPPER_A)));

        // odometer, no notches
        carry = 1'b1;
        for (int r = 0; r < ROTOR_COUNT; r++)
        begin
            adv[r] = pos_reg[r];
            if (carry)
            begin
                adv[r] = (pos_reg[r] == TOP_POS) ? '0 : pos_reg[r] + 1'b1;
            end
            carry = carry && (pos_reg[r] == TOP_POS);
        end

        // lookup chain: finish stage k, issue stage k+1
        if (stg_is_rotor(k_cur))
        begin
            raw = rot_rdata;
        end
        else if (stg_is_refl(k_cur))
        begin
            raw = refl_rdata;
        end
        else
        begin
            raw = plug_rdata;
        end
        vr        = reduce(raw);
        val       = stg_is_rotor(k_cur) ? sub_mod(vr, off_a_reg) : vr;
        ltr_raddr = val;
        rot_raddr = rot_base(stg_rotor(k_cur + 1)) + RAW'(add_mod(val, off_b_reg));
        r_ahead   = stg_rotor(k_cur + 2);

        unique case (state_reg)
            ST_IDLE:
            begin
                ltr_raddr = c0;
                if (q_valid && (!needs_out || out_free))
                begin
                    pop = 1'b1;
                    case (q_head.kind)
                        CMD_LETTER:
                        begin
                            pos_next   = adv;
                            off_a_next = '0;
                            off_b_next = add_mod(adv[0], ring[0]);
                            k_next     = '0;
                            lower_next = q_head.lower_out;
                            state_next = ST_RUN;
                        end
                        CMD_PASS:
                        begin
                            out_valid_next   = 1'b1;
                            out_char_next    = q_head.char_val;
                            out_refused_next = 1'b0;
                        end
                        CMD_REFUSE:
                        begin
                            out_valid_next   = 1'b1;
                            out_char_next    = '0;
                            out_refused_next = 1'b1;
                        end
                        CMD_LOAD_ROTOR:
                        begin
                            rot_we = 1'b1;
                        end
                        CMD_LOAD_REFL:
                        begin
                            refl_we = 1'b1;
                        end
                        CMD_LOAD_PLUG:
                        begin
                            plug_we = 1'b1;
                        end
                        CMD_SET_POS:
                        begin
                            pos_next[RW'(q_head.sel)] = reduce(q_head.value);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                off_a_next = off_b_reg;
                off_b_next = add_mod(pos_reg[r_ahead], ring[r_ahead]);
                k_next     = k_reg + 1'b1;
                if (k_cur == NSTG - 1)
                begin
                    out_valid_next   = 1'b1;
                    out_char_next    = (lower_reg ? CHAR_LOWER_A : CHAR_UPPER_A) + CHAR_W'(val);
                    out_refused_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            k_reg           <= '0;
            pos_reg         <= '0;
            off_a_reg       <= '0;
            off_b_reg       <= '0;
            lower_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_char_reg    <= '0;
            out_refused_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            pos_reg         <= pos_next;
            off_a_reg       <= off_a_next;
            off_b_reg       <= off_b_next;
            lower_reg       <= lower_next;
            out_valid_reg   <= out_valid_next;
            out_char_reg    <= out_char_next;
            out_refused_reg <= out_refused_next;
        end
    end

    rcl_ram #(.WIDTH(SYM_W), .DEPTH(ALPHABET_SIZE)) u_plug_ram (
        .clk   (clk),
        .we    (plug_we),
        .waddr (ltr_waddr),
        .wdata (q_head.value),
        .raddr (ltr_raddr),
        .rdata (plug_rdata)
    );

    rcl_ram #(.WIDTH(SYM_W), .DEPTH(ALPHABET_SIZE)) u_refl_ram (
        .clk   (clk),
        .we    (refl_we),
        .waddr (ltr_waddr),
        .wdata (q_head.value),
        .raddr (ltr_raddr),
        .rdata (refl_rdata)
    );

    rcl_ram #(.WIDTH(SYM_W), .DEPTH(RDEPTH)) u_rotor_ram (
        .clk   (clk),
        .we    (rot_we),
        .waddr (rot_waddr),
        .wdata (q_head.value),
        .raddr (rot_raddr),
        .rdata (rot_rdata)
    );

    assign dout.valid    = out_valid_reg;
    assign dout.char_out = out_char_reg;
    assign dout.refused  = out_refused_reg;
    assign status.busy   = (state_reg == ST_RUN);
    assign status.pop    = pop;

endmodule
